### rtl/lkc_pkg.sv
package lkc_pkg;

   localparam int KEY_W           = 32;
   localparam int CAP_W           = 5;
   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;    // capture a new item and clear the scan trackers
      logic rd_en;    // read one key entry at the scan address
      logic update;   // apply the state change and load the result register
   } lkc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free; // the result register can take a new result this cycle
   } lkc_status_type;

endpackage

### rtl/lkc_ctrl.sv
module lkc_ctrl #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lkc_pkg::lkc_status_type status,
   output lkc_pkg::lkc_cmd_type    cmd,
   output logic [IDX_W-1:0]        rd_addr
);
   import lkc_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      UPDATE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             ready_ff, ready_in;

   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(ENTRIES - 1);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      ready_in = ready_ff;
      case (state_ff)
         IDLE: begin
            if (req_tvalid && ready_ff) begin
               state_in = SCAN;
               addr_in  = '0;
               ready_in = 1'b0;
            end
         end
         SCAN: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         DRAIN: begin
            state_in = UPDATE;
         end
         UPDATE: begin
            if (status.out_free) begin
               state_in = IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         addr_ff  <= '0;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;
   assign rd_addr    = addr_ff;
   assign cmd.start  = req_tvalid && ready_ff;
   assign cmd.rd_en  = (state_ff == SCAN);
   assign cmd.update = (state_ff == UPDATE) && status.out_free;

endmodule

### rtl/lkc_datapath.sv
module lkc_datapath #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_op,
   input  logic [lkc_pkg::KEY_W-1:0] req_key,
   input  logic                      csr_valid,
   input  logic [lkc_pkg::CAP_W-1:0] csr_data,
   input  lkc_pkg::lkc_cmd_type      cmd,
   input  logic [IDX_W-1:0]          rd_addr,
   output lkc_pkg::lkc_status_type   status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_hit,
   output logic                      rsp_evicted,
   output logic [lkc_pkg::KEY_W-1:0] rsp_evicted_key
);
   import lkc_pkg::*;

   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

   // Key store, read one entry per scan cycle and written once per insert.
   logic [KEY_W-1:0]  key_mem [ENTRIES];
   logic [KEY_W-1:0]  rd_key_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff;

   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_W-1:0]  rank_ff [ENTRIES];
   logic [RANK_W-1:0]  rank_in [ENTRIES];
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [CAP_W-1:0]   cap_ff;

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  found_idx_ff, found_idx_in;
   logic [RANK_W-1:0] found_rank_ff, found_rank_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [RANK_W-1:0] best_rank_ff, best_rank_in;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;

   logic              rsp_valid_ff;
   logic              hit_ff;
   logic              evicted_ff;
   logic [KEY_W-1:0]  evicted_key_ff;

   logic              cur_valid;
   logic [RANK_W-1:0] cur_rank;
   logic [CMP_W-1:0]  cap_ext;
   logic [CMP_W-1:0]  eff_cap;
   logic              full;
   logic              evict;
   logic              insert;
   logic [IDX_W-1:0]  slot;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
      cmp_idx_ff <= rd_addr;
      if (cmd.update && insert) begin
         key_mem[slot] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   // Scan trackers: first match, first free slot, and least recent valid entry.
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_rank  = rank_ff[cmp_idx_ff];

   always_comb begin
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_rank_in  = best_rank_ff;
      best_key_in   = best_key_ff;
      if (cmd.start) begin
         found_in = 1'b0;
         free_in  = 1'b0;
         best_in  = 1'b0;
      end else if (cmp_vld_ff) begin
         if (cur_valid && (rd_key_ff == key_ff) && !found_ff) begin
            found_in      = 1'b1;
            found_idx_in  = cmp_idx_ff;
            found_rank_in = cur_rank;
         end
         if (!cur_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
         if (cur_valid && (!best_ff || (cur_rank > best_rank_ff))) begin
            best_in      = 1'b1;
            best_idx_in  = cmp_idx_ff;
            best_rank_in = cur_rank;
            best_key_in  = rd_key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_rank_ff  <= best_rank_in;
      best_key_ff   <= best_key_in;
   end

   // A capacity of zero acts as one, and any above the entry count as the count.
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full   = (CMP_W'(occ_ff) >= eff_cap);
   assign evict  = !found_ff && (op_ff == OP_PUT) && full && best_ff;
   assign insert = !found_ff && (op_ff == OP_PUT) && (evict || free_ff);
   assign slot   = evict ? best_idx_ff : free_idx_ff;

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.update) begin
            if (found_ff) begin
               if (valid_ff[i] && (rank_ff[i] < found_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
               if (IDX_W'(i) == found_idx_ff) begin
                  rank_in[i] = '0;
               end
            end else if (insert) begin
               if (valid_ff[i] && !(evict && (IDX_W'(i) == best_idx_ff))) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
               if (IDX_W'(i) == slot) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end
            end
         end
      end
      if (cmd.update && insert && !evict) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         hit_ff         <= found_ff;
         evicted_ff     <= evict;
         evicted_key_ff <= evict ? best_key_ff : '0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

### rtl/lru_key_cache.sv
// Fully associative key cache with least-recently-used replacement.
//
// The request stream carries one get or put per transfer: the key in req_tdata
// and the operation in req_tuser (0 get, 1 put). The response stream returns
// exactly one transfer per request, in order: the hit and evicted flags in
// rsp_tuser and the evicted key (zero when nothing was evicted) in rsp_tdata.
// The csr channel writes the capacity register and is always ready. The user must
// write it only while the cache is idle; the block itself does not enforce this.
//
// Each request scans the key store one entry per cycle through its single
// read port, so a request occupies the cache for an accept step, a read of
// every entry, a compare step for the last read, and an update step. The
// response is registered at the update, and the request side is ready again
// from the cycle in which the response appears.
//
// The response sits in an output register. When the receiver stalls, the next
// request is still accepted and scanned; only its update waits until the
// pending response has been taken.
//
// Reset is synchronous and active high; it empties the cache and sets capacity 16.
module lru_key_cache #(
   parameter int ENTRIES = lkc_pkg::ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request: tdata = key[31:0]; tuser = operation[0].
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lkc_pkg::KEY_W-1:0]   req_tdata,
   input  logic                        req_tuser,
   // Response: tdata = evicted_key[31:0]; tuser = hit[0], evicted[1].
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lkc_pkg::KEY_W-1:0]   rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   // Capacity register write.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lkc_pkg::CAP_W-1:0]   csr_data
);
   import lkc_pkg::*;

   // Index and rank width; at least one bit so a single-entry cache still builds.
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   lkc_cmd_type      cmd;
   lkc_status_type   status;
   logic [IDX_W-1:0] rd_addr;
   logic             hit;
   logic             evicted;

   assign csr_ready = 1'b1;

   lkc_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   lkc_datapath #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_tuser),
      .req_key         (req_tdata),
      .csr_valid       (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_hit         (hit),
      .rsp_evicted     (evicted),
      .rsp_evicted_key (rsp_tdata)
   );

   assign rsp_tuser = {evicted, hit};

endmodule

### sim/lru_key_cache_checker.sv
module lru_key_cache_checker #(
   parameter int ENTRIES = lkc_pkg::ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [lkc_pkg::KEY_W-1:0] req_tdata,
   input  logic                      req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [lkc_pkg::KEY_W-1:0] rsp_tdata,
   input  logic [1:0]                rsp_tuser,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [lkc_pkg::CAP_W-1:0] csr_data,
   output int                        mismatch_count,
   output int                        outstanding,
   output int                        hit_count,
   output int                        eviction_count
);
   import lkc_pkg::*;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } access_outcome_type;

   // Shadow copy of the cache contents and its capacity register.
   logic [KEY_W-1:0] line_key   [ENTRIES];
   logic             line_valid [ENTRIES];
   int               line_rank  [ENTRIES];
   int               line_count;
   logic [CAP_W-1:0] capacity;

   access_outcome_type access_outcomes [$];
   int                 mismatches;
   int                 hits;
   int                 evictions;

   // Applies one get or put to the shadow cache and returns what the cache must report.
   function automatic access_outcome_type cache_access(input logic             op,
                                                       input logic [KEY_W-1:0] key);
      access_outcome_type outcome;
      int                 i;
      int                 found;
      int                 victim;
      int                 slot;
      int                 limit;
      int                 old_rank;
      outcome = '0;
      found   = -1;
      victim  = -1;
      slot    = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (found < 0 && line_valid[i] && line_key[i] == key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         // Promote: entries more recent than the hit age by one.
         old_rank = line_rank[found];
         for (i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && line_rank[i] < old_rank) begin
               line_rank[i]++;
            end
         end
         line_rank[found] = 0;
         outcome.hit = 1'b1;
         return outcome;
      end
      if (op == OP_GET) begin
         return outcome;
      end
      limit = int'(capacity);
      if (limit < 1) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      if (line_count >= limit) begin
         for (i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) begin
               victim = i;
            end
         end
         outcome.evicted     = 1'b1;
         outcome.evicted_key = line_key[victim];
         line_valid[victim]  = 1'b0;
         line_count--;
         slot = victim;
      end else begin
         for (i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !line_valid[i]) begin
               slot = i;
            end
         end
      end
      for (i = 0; i < ENTRIES; i++) begin
         if (line_valid[i]) begin
            line_rank[i]++;
         end
      end
      line_key[slot]   = key;
      line_valid[slot] = 1'b1;
      line_rank[slot]  = 0;
      line_count++;
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      access_outcome_type want;
      int                 i;
      if (reset) begin
         for (i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = 0;
         end
         line_count = 0;
         capacity   = CAPACITY_RESET;
         access_outcomes.delete();
         mismatches = 0;
         hits       = 0;
         evictions  = 0;
      end else begin
         // Responses are matched first, so a request taken in the same cycle
         // can never stand in for a response that came out of nowhere.
         if (rsp_tvalid && rsp_tready) begin
            if (access_outcomes.size() == 0) begin
               $display("%0t: unexpected response, expected none, got tuser %b tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = access_outcomes.pop_front();
               if (rsp_tuser[0] !== want.hit) begin
                  $display("%0t: hit expected %b, got %b", $time, want.hit, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[1] !== want.evicted) begin
                  $display("%0t: evicted expected %b, got %b", $time, want.evicted, rsp_tuser[1]);
                  mismatches++;
               end
               if (rsp_tdata !== want.evicted_key) begin
                  $display("%0t: evicted_key expected %h, got %h",
                           $time, want.evicted_key, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            capacity = csr_data;
         end
         if (req_tvalid && req_tready) begin
            want = cache_access(req_tuser, req_tdata);
            if (want.hit) hits++;
            if (want.evicted) evictions++;
            access_outcomes.push_back(want);
         end
      end
      mismatch_count <= mismatches;
      outstanding    <= access_outcomes.size();
      hit_count      <= hits;
      eviction_count <= evictions;
   end

endmodule

### sim/lru_key_cache_tb.sv
// Drives get and put requests into the key cache, steps the capacity register
// through settings from 0 to 31 between phases, and leaves all checking to the
// checker instance that watches the three channels.
module lru_key_cache_tb;
   import lkc_pkg::*;

   // One request keeps the cache busy for a full scan of the key store plus
   // the accept, compare and update cycles.
   localparam int SERVICE_CYCLES    = ENTRIES_DEFAULT + 3;
   localparam int ITEMS_PER_SETTING = 180;
   localparam int HOLD_OFF_CYCLES   = 300;
   // The longest quiet stretch of a correct run is a hold-off plus one scan
   // plus a sender gap, and the limit must stay above that.
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int POOL_DEPTH        = 24;
   localparam int SETTING_COUNT     = 10;

   // Receiver stall patterns.
   localparam int READY_ALWAYS = 0;
   localparam int READY_HALF   = 1;
   localparam int READY_RARE   = 2;
   localparam int READY_MOSTLY = 3;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [KEY_W-1:0] req_tdata  = '0;  // key[31:0]
   logic             req_tuser  = OP_GET;  // operation[0]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [KEY_W-1:0] rsp_tdata;  // evicted_key[31:0]
   logic [1:0]       rsp_tuser;  // hit[0], evicted[1]
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data   = '0;

   int mismatch_count;
   int outstanding;
   int hit_count;
   int eviction_count;

   // Capacity settings in the order they are written. The run starts at the
   // reset value of 16 and the first write drops straight to 1 with the cache
   // full, so later put misses must evict one key each without shrinking the
   // occupancy. Zero must act as 1, and 17 and 31 must act as 16.
   int capacity_steps [SETTING_COUNT] = '{1, 0, 31, 5, 16, 17, 2, 12, 3, 8};

   logic [KEY_W-1:0] key_pool [POOL_DEPTH];
   int  burst_left      = 0;
   int  requests_sent   = 0;
   int  hold_offs_done  = 0;
   bit  hold_off_asked  = 1'b0;
   int  quiet_cycles    = 0;

   lru_key_cache u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lru_key_cache_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .hit_count      (hit_count),
      .eviction_count (eviction_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Offers one request and returns right after the edge that takes it.
   // Requests go out in bursts; between bursts the valid line drops for a
   // random number of cycles, sometimes none at all.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      requests_sent++;
   endtask

   // Stops offering requests and waits until every response has been taken,
   // which leaves the cache idle since each request yields one response.
   task automatic wait_until_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: segments of random length, each with its own stall
   // pattern. When the stimulus asks for it, ready stays low for a long
   // stretch while requests keep coming, so the cache backs up and has to
   // hold off its request side.
   initial begin : receiver
      int seg_len;
      int mode;
      forever begin
         seg_len = $urandom_range(5, 60);
         mode    = $urandom_range(READY_ALWAYS, READY_MOSTLY);
         repeat (seg_len) begin
            @(negedge clock);
            if (hold_off_asked) begin
               hold_off_asked = 1'b0;
               rsp_tready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
               hold_offs_done++;
            end
            case (mode)
               READY_ALWAYS: begin
                  rsp_tready <= 1'b1;
               end
               READY_HALF: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               READY_RARE: begin
                  rsp_tready <= ($urandom_range(0, 7) == 0);
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 3) != 0);
               end
            endcase
         end
      end
   end

   // Watchdog: any cycle without a transfer on some channel counts toward
   // the limit, so a hung handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int               phase;
      int               n;
      int               limit;
      int               pool_used;
      logic             op;
      logic [KEY_W-1:0] key;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity of 16. A get on the empty cache
      // misses, the extreme key patterns go in and are found again, a put of
      // a key already held only promotes it, and once the store is full the
      // next put miss evicts the oldest key, which then misses.
      send_request(OP_GET, 32'h0000_0000);
      send_request(OP_PUT, 32'h8000_0000);
      send_request(OP_PUT, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h0000_0000);
      send_request(OP_PUT, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h8000_0000);
      send_request(OP_GET, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h0000_0000);
      send_request(OP_GET, 32'hFFFF_FFFE);
      for (n = 0; n < 12; n++) begin
         send_request(OP_PUT, 32'h0000_0A00 + n);
      end
      send_request(OP_PUT, 32'h5555_AAAA);
      send_request(OP_GET, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h7FFF_FFFF);
      wait_until_idle();

      // Random part: each phase draws most keys from a pool a little larger
      // than the capacity, so hits, promotions and evictions all happen
      // often. The pool partly carries over between phases, so the contents
      // left by one setting are hit under the next.
      for (phase = 0; phase < SETTING_COUNT; phase++) begin
         write_capacity(CAP_W'(capacity_steps[phase]));
         limit = capacity_steps[phase];
         if (limit < 1) limit = 1;
         if (limit > ENTRIES_DEFAULT) limit = ENTRIES_DEFAULT;
         pool_used = limit + $urandom_range(1, 6);
         for (n = 0; n < POOL_DEPTH; n++) begin
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
               key_pool[n] = $urandom;
            end
         end
         for (n = 0; n < ITEMS_PER_SETTING; n++) begin
            if ((phase == 2 || phase == 6) && n == 60) begin
               hold_off_asked = 1'b1;
            end
            op  = ($urandom_range(0, 9) < 6) ? OP_PUT : OP_GET;
            key = ($urandom_range(0, 4) == 0) ? $urandom
                                               : key_pool[$urandom_range(0, pool_used - 1)];
            send_request(op, key);
         end
         wait_until_idle();
      end

      repeat (2 * SERVICE_CYCLES) @(posedge clock);
      $display("Checked %0d cache requests (%0d hits, %0d evictions) over %0d capacity settings,",
               requests_sent, hit_count, eviction_count, SETTING_COUNT + 1);
      $display("with bursty requests, random response stalls and %0d long response hold-offs.",
               hold_offs_done);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
